/* sv/vtesc_pkg.sv */
// Shared types, constants and lookup functions of the escape sequence parser.
`default_nettype none
package vtesc_pkg;

  // Sizing of the parameter store and the OSC string limit
  localparam int MAX_PARAMS  = 32;
  localparam int MAX_OSC_LEN = 8192;
  localparam int PADDR_W     = $clog2(MAX_PARAMS + 1);
  localparam int OSC_W       = $clog2(MAX_OSC_LEN + 1);

  // Byte codes of interest
  localparam logic [7:0] B_BEL   = 8'h07;
  localparam logic [7:0] B_SO    = 8'h0E;
  localparam logic [7:0] B_SI    = 8'h0F;
  localparam logic [7:0] B_CAN   = 8'h18;
  localparam logic [7:0] B_SUB   = 8'h1A;
  localparam logic [7:0] B_ESC   = 8'h1B;
  localparam logic [7:0] B_DEL   = 8'h7F;
  localparam logic [7:0] B_CSI   = 8'h5B;
  localparam logic [7:0] B_OSC   = 8'h5D;
  localparam logic [7:0] B_DCS   = 8'h50;
  localparam logic [7:0] B_SOS   = 8'h58;
  localparam logic [7:0] B_PM    = 8'h5E;
  localparam logic [7:0] B_APC   = 8'h5F;
  localparam logic [7:0] B_ST    = 8'h5C;
  localparam logic [7:0] B_RIS   = 8'h63;
  localparam logic [7:0] B_STR_P = 8'h70;
  localparam logic [7:0] B_BANG  = 8'h21;
  localparam logic [7:0] B_G0    = 8'h28;
  localparam logic [7:0] B_G1A   = 8'h29;
  localparam logic [7:0] B_G1B   = 8'h2A;
  localparam logic [7:0] B_G1C   = 8'h2B;
  localparam logic [7:0] SET_US  = 8'h42;
  localparam logic [7:0] SET_GFX = 8'h30;

  localparam logic [20:0] CP_REPL   = 21'h00FFFD;
  localparam logic [20:0] CAP_VALUE = 21'h100000;

  typedef enum logic [3:0] {
    PS_GROUND, PS_ESC, PS_ESC_INTER, PS_CSI_ENTRY, PS_CSI_PARAM, PS_CSI_INTER,
    PS_CSI_IGNORE, PS_OSC, PS_DCS_IGNORE, PS_STR_IGNORE
  } pstate_t;

  typedef enum logic [2:0] {
    EV_PRINT, EV_EXEC, EV_ESC, EV_CSI, EV_OSC, EV_OSC_END
  } ev_kind_t;

  // Results caused by one byte
  typedef enum logic [1:0] {NRES_NONE, NRES_ONE, NRES_TWO, NRES_CSI} nres_t;
  // Source of the output register load
  typedef enum logic [1:0] {LD_NONE, LD_FIRST, LD_SECOND, LD_WALK} load_t;
  typedef enum logic [1:0] {CS_IDLE, CS_SECOND, CS_READ, CS_WALK} ctrl_state_t;

  typedef struct packed {
    logic  accept;
    load_t load;
    logic  last;
    logic  walk_step;
  } ctl_cmd_t;

  typedef struct packed {
    nres_t nres;
    logic  out_free;
    logic  walk_done;
  } dp_status_t;

  typedef struct packed {
    ev_kind_t    kind;
    logic [20:0] code;
    logic [7:0]  ib;
    logic [1:0]  ic;
    logic        pf;
    logic [5:0]  pi;
    logic [20:0] pv;
    logic        po;
    logic [5:0]  pt;
  } res_t;

  // DEC special graphics for 0x5F..0x7E
  function automatic logic [20:0] dec_gfx(input logic [4:0] idx);
    logic [20:0] r;
    case (idx)
      5'd0:  r = 21'h00A0;  5'd1:  r = 21'h25C6;  5'd2:  r = 21'h2592;  5'd3:  r = 21'h2409;
      5'd4:  r = 21'h240C;  5'd5:  r = 21'h240D;  5'd6:  r = 21'h240A;  5'd7:  r = 21'h00B0;
      5'd8:  r = 21'h00B1;  5'd9:  r = 21'h2424;  5'd10: r = 21'h240B;  5'd11: r = 21'h2518;
      5'd12: r = 21'h2510;  5'd13: r = 21'h250C;  5'd14: r = 21'h2514;  5'd15: r = 21'h253C;
      5'd16: r = 21'h23BA;  5'd17: r = 21'h23BB;  5'd18: r = 21'h2500;  5'd19: r = 21'h23BC;
      5'd20: r = 21'h23BD;  5'd21: r = 21'h251C;  5'd22: r = 21'h2524;  5'd23: r = 21'h2534;
      5'd24: r = 21'h252C;  5'd25: r = 21'h2502;  5'd26: r = 21'h2264;  5'd27: r = 21'h2265;
      5'd28: r = 21'h03C0;  5'd29: r = 21'h2260;  5'd30: r = 21'h00A3;  default: r = 21'h00B7;
    endcase
    return r;
  endfunction

  function automatic logic [20:0] translate(input logic [20:0] cp, input logic [7:0] set);
    logic [20:0] off;
    off = cp - 21'h5F;
    if (set == SET_GFX && cp >= 21'h5F && cp <= 21'h7E) return dec_gfx(off[4:0]);
    return cp;
  endfunction

endpackage
`default_nettype wire

/* sv/vt_escape_sequence_parser_top.sv */
// Top level of the VT escape sequence parser with UTF-8 decoding.
// Takes one byte per beat and gives zero or more event beats per byte, the last
// of them marked by out_tlast. A byte that gives at most one event loads one
// beat; a byte that gives a replacement character plus a print loads the two in
// turn; a CSI final byte with N stored parameters gives N beats: the accepting
// cycle, then for each parameter one registered read of the parameter store
// followed by its output beat. Input is taken only while the output register is
// free or being drained, so stalls on the output side hold back the input.
`default_nettype none
module vt_escape_sequence_parser_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // byte_in
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [71:0] out_tdata,  // code, inter_byte, inter_count, private_flag,
                                  // param_index, param_value, param_omitted,
                                  // param_total, zero pad
  output logic [2:0]  out_tuser,  // event_kind
  output logic        out_tlast   // last
);
  import vtesc_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t st;
  res_t       res;

  vtesc_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .st, .cmd
  );

  vtesc_dp u_dp (
    .clk, .rst_n, .byte_in(in_tdata), .cmd, .st, .out_tready,
    .out_valid(out_tvalid), .out_res(res), .out_last(out_tlast)
  );

  assign out_tuser = res.kind;
  assign out_tdata = {6'b0, res.pt, res.po, res.pv, res.pi, res.pf, res.ic, res.ib,
                      res.code};

  // A print that is not last is always the replacement character
  a_repl_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == EV_PRINT && !out_tlast |-> out_tdata[20:0] == CP_REPL)
    else $error("non-final print is not U+FFFD");

  // OSC end closes its run and carries no code
  a_osc_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == EV_OSC_END |-> out_tlast && out_tdata[20:0] == 21'd0)
    else $error("bad osc end beat");

  // The last CSI beat carries the last parameter index
  a_csi_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == EV_CSI && out_tlast && out_tdata[65:60] != 6'd0
    |-> out_tdata[37:32] == out_tdata[65:60] - 6'd1)
    else $error("csi run ended early");

endmodule
`default_nettype wire

/* sv/vtesc_ctrl.sv */
// Controller: input handshake and sequencing of the result beats.
`default_nettype none
module vtesc_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  vtesc_pkg::dp_status_t st,
  output vtesc_pkg::ctl_cmd_t   cmd
);
  import vtesc_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= CS_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    cmd           = '0;
    cmd.load      = LD_NONE;
    case (state_r)
      CS_IDLE: begin
        in_tready  = st.out_free;
        cmd.accept = in_tvalid && st.out_free;
        if (cmd.accept) begin
          case (st.nres)
            NRES_ONE: begin
              cmd.load = LD_FIRST;
              cmd.last = 1'b1;
            end
            NRES_TWO: begin
              cmd.load  = LD_FIRST;
              state_nxt = CS_SECOND;
            end
            NRES_CSI: state_nxt = CS_READ;
            default: ;
          endcase
        end
      end
      CS_SECOND: begin
        if (st.out_free) begin
          cmd.load  = LD_SECOND;
          cmd.last  = 1'b1;
          state_nxt = CS_IDLE;
        end
      end
      CS_READ: state_nxt = CS_WALK;
      CS_WALK: begin
        if (st.out_free) begin
          cmd.load = LD_WALK;
          cmd.last = st.walk_done;
          if (st.walk_done) begin
            state_nxt = CS_IDLE;
          end else begin
            cmd.walk_step = 1'b1;
            state_nxt     = CS_READ;
          end
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* sv/vtesc_dp.sv */
// Datapath: parser state, UTF-8 decode, parameter store and output register.
`default_nettype none
module vtesc_dp (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire [7:0]             byte_in,
  input  vtesc_pkg::ctl_cmd_t   cmd,
  output vtesc_pkg::dp_status_t st,
  input  wire                   out_tready,
  output logic                  out_valid,
  output vtesc_pkg::res_t       out_res,
  output logic                  out_last
);
  import vtesc_pkg::*;

  pstate_t     ps_r, ps_nxt;
  logic [20:0] cp_r, cp_nxt;
  logic [1:0]  cont_r, cont_nxt;
  logic        pend_r, pend_nxt;
  logic [5:0]  used_r, used_nxt;
  logic [20:0] cur_r, cur_nxt;
  logic [7:0]  fi_r, fi_nxt;
  logic [1:0]  is_r, is_nxt;
  logic        priv_r, priv_nxt;
  logic [7:0]  g0_r, g0_nxt, g1_r, g1_nxt;
  logic        so_r, so_nxt;
  logic [OSC_W-1:0] osc_r, osc_nxt;

  // Latched CSI dispatch context and walk index
  res_t        dsp_r, dsp_nxt;
  logic [5:0]  widx_r;
  logic [21:0] rd_data_r;
  logic [21:0] mem [MAX_PARAMS+1];
  res_t        walk_res;

  logic        mem_we;
  logic [PADDR_W-1:0] mem_waddr;
  logic [21:0] mem_wdata;

  res_t        res0, res1, sec_r;
  nres_t       nres;
  logic        valid_r;
  res_t        out_r;
  logic        last_r;

  logic [7:0]  b;
  logic [7:0]  set_act;
  logic        clear;
  logic        opened;
  logic [5:0]  used_n;
  logic [20:0] base;
  logic [24:0] acc;
  logic        pre_repl;
  res_t        tail;
  logic        tail_v;

  assign b       = byte_in;
  assign set_act = so_r ? g1_r : g0_r;

  // Per-byte parse step
  always_comb begin
    ps_nxt = ps_r; cp_nxt = cp_r; cont_nxt = cont_r; pend_nxt = pend_r;
    used_nxt = used_r; cur_nxt = cur_r; fi_nxt = fi_r; is_nxt = is_r;
    priv_nxt = priv_r; g0_nxt = g0_r; g1_nxt = g1_r; so_nxt = so_r; osc_nxt = osc_r;
    dsp_nxt = dsp_r;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0;
    res0 = '0; res1 = '0; nres = NRES_NONE; clear = 1'b0;
    opened = 1'b0; used_n = used_r; base = '0; acc = '0;
    pre_repl = 1'b0; tail = '0; tail_v = 1'b0;

    if (ps_r == PS_OSC) begin
      if (b == B_BEL || b == B_ESC) begin
        res0.kind = EV_OSC_END; nres = NRES_ONE; osc_nxt = '0;
        ps_nxt = (b == B_ESC) ? PS_ESC : PS_GROUND;
        if (b == B_ESC) begin
          fi_nxt = '0; is_nxt = '0;
        end
      end else if (osc_r < OSC_W'(MAX_OSC_LEN)) begin
        osc_nxt = osc_r + 1'b1;
        res0.kind = EV_OSC; res0.code = {13'b0, b}; nres = NRES_ONE;
      end
    end else if (ps_r == PS_DCS_IGNORE || ps_r == PS_STR_IGNORE) begin
      if (b == B_ESC) begin
        ps_nxt = PS_ESC; fi_nxt = '0; is_nxt = '0;
      end else if (b == B_BEL) begin
        ps_nxt = PS_GROUND;
      end
    end else if (b == B_ESC) begin
      ps_nxt = PS_ESC; fi_nxt = '0; is_nxt = '0;
    end else if (b < 8'h20) begin
      // C0 control
      if (b == B_SO) so_nxt = 1'b1;
      else if (b == B_SI) so_nxt = 1'b0;
      else if (b == B_CAN || b == B_SUB) ps_nxt = PS_GROUND;
      res0.kind = EV_EXEC; res0.code = {13'b0, b}; nres = NRES_ONE;
    end else if (ps_r == PS_GROUND) begin
      if (b != B_DEL) begin
        if (cont_r != 2'd0 && b[7:6] == 2'b10) begin
          cp_nxt   = {cp_r[14:0], b[5:0]};
          cont_nxt = cont_r - 1'b1;
          if (cont_r == 2'd1) begin
            res0.kind = EV_PRINT; res0.code = translate(cp_nxt, set_act);
            nres = NRES_ONE;
          end
        end else begin
          if (cont_r != 2'd0) begin
            cont_nxt = '0; pre_repl = 1'b1;
          end
          tail.kind = EV_PRINT;
          if (!b[7]) begin
            tail.code = translate({13'b0, b}, set_act); tail_v = 1'b1;
          end else if (b[7:5] == 3'b110) begin
            cp_nxt = {16'b0, b[4:0]}; cont_nxt = 2'd1;
          end else if (b[7:4] == 4'b1110) begin
            cp_nxt = {17'b0, b[3:0]}; cont_nxt = 2'd2;
          end else if (b[7:3] == 5'b11110) begin
            cp_nxt = {18'b0, b[2:0]}; cont_nxt = 2'd3;
          end else begin
            tail.code = CP_REPL; tail_v = 1'b1;
          end
          if (pre_repl) begin
            res0.kind = EV_PRINT; res0.code = CP_REPL; res1 = tail;
            nres = tail_v ? NRES_TWO : NRES_ONE;
          end else if (tail_v) begin
            res0 = tail; nres = NRES_ONE;
          end
        end
      end
    end else if (ps_r == PS_ESC || ps_r == PS_ESC_INTER) begin
      if (b <= 8'h2F) begin
        if (is_r == 2'd0) fi_nxt = b;
        if (is_r != 2'd2) is_nxt = is_r + 1'b1;
        ps_nxt = PS_ESC_INTER;
      end else begin
        case (b)
          B_CSI: begin
            ps_nxt = PS_CSI_ENTRY; used_nxt = '0; pend_nxt = 1'b0;
            fi_nxt = '0; is_nxt = '0; priv_nxt = 1'b0;
          end
          B_OSC: begin
            ps_nxt = PS_OSC; osc_nxt = '0;
          end
          B_DCS: ps_nxt = PS_DCS_IGNORE;
          B_SOS, B_PM, B_APC: ps_nxt = PS_STR_IGNORE;
          B_ST: ps_nxt = PS_GROUND;
          default: begin
            res0.kind = EV_ESC; res0.code = {13'b0, b}; res0.ib = fi_r; res0.ic = is_r;
            nres = NRES_ONE; ps_nxt = PS_GROUND;
            if (is_r != 2'd0) begin
              if (fi_r == B_G0) g0_nxt = b;
              else if (fi_r == B_G1A || fi_r == B_G1B || fi_r == B_G1C) g1_nxt = b;
            end else if (b == B_RIS) begin
              clear = 1'b1;
            end
          end
        endcase
      end
    end else if (ps_r == PS_CSI_IGNORE) begin
      if (b >= 8'h40 && b <= 8'h7E) ps_nxt = PS_GROUND;
    end else begin
      // CSI entry, parameter and intermediate states
      if (b >= 8'h30 && b <= 8'h39) begin
        opened = !pend_r && used_r < 6'(MAX_PARAMS + 1);
        used_n = opened ? used_r + 1'b1 : used_r;
        base   = opened ? '0 : cur_r;
        acc    = ({4'b0, base} << 3) + ({4'b0, base} << 1) + {21'b0, b[3:0]};
        if (used_n != 6'd0 && used_n <= 6'(MAX_PARAMS)) begin
          cur_nxt = (acc > {4'b0, CAP_VALUE}) ? CAP_VALUE : acc[20:0];
          mem_we  = 1'b1;
        end else begin
          cur_nxt = base;
          mem_we  = opened;
        end
        mem_waddr = PADDR_W'(used_n - 1'b1);
        mem_wdata = {1'b0, cur_nxt};
        used_nxt = used_n; pend_nxt = 1'b1; ps_nxt = PS_CSI_PARAM;
      end else if (b == 8'h3A || b == 8'h3B) begin
        used_n = used_r;
        if (!pend_r && used_r < 6'(MAX_PARAMS + 1)) begin
          mem_we = 1'b1; mem_waddr = PADDR_W'(used_r); mem_wdata = {1'b1, 21'b0};
          used_n = used_r + 1'b1;
        end
        used_nxt = used_n; pend_nxt = 1'b0;
        ps_nxt = (used_n > 6'(MAX_PARAMS)) ? PS_CSI_IGNORE : PS_CSI_PARAM;
      end else if (b >= 8'h3C && b <= 8'h3F) begin
        priv_nxt = 1'b1; ps_nxt = PS_CSI_PARAM;
      end else if (b >= 8'h20 && b <= 8'h2F) begin
        if (is_r == 2'd0) fi_nxt = b;
        if (is_r != 2'd2) is_nxt = is_r + 1'b1;
        ps_nxt = PS_CSI_INTER;
      end else if (b >= 8'h40 && b <= 8'h7E) begin
        res0.kind = EV_CSI; res0.code = {13'b0, b}; res0.ib = fi_r; res0.ic = is_r;
        res0.pf = priv_r;
        if (used_r == 6'd0) begin
          res0.po = 1'b1; nres = NRES_ONE;
        end else begin
          res0.pt = used_r; dsp_nxt = res0; nres = NRES_CSI;
        end
        ps_nxt = PS_GROUND; used_nxt = '0; pend_nxt = 1'b0;
        fi_nxt = '0; is_nxt = '0; priv_nxt = 1'b0;
        clear = (b == B_STR_P && is_r == 2'd1 && fi_r == B_BANG);
      end
    end

    // RIS and DECSTR
    if (clear) begin
      ps_nxt = PS_GROUND; cp_nxt = '0; cont_nxt = '0; pend_nxt = 1'b0; used_nxt = '0;
      fi_nxt = '0; is_nxt = '0; priv_nxt = 1'b0; g0_nxt = SET_US; g1_nxt = SET_US;
      so_nxt = 1'b0; osc_nxt = '0;
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r <= PS_GROUND; cp_r <= '0; cont_r <= '0; pend_r <= 1'b0; used_r <= '0;
      fi_r <= '0; is_r <= '0; priv_r <= 1'b0; g0_r <= SET_US; g1_r <= SET_US;
      so_r <= 1'b0; osc_r <= '0;
    end else if (cmd.accept) begin
      ps_r <= ps_nxt; cp_r <= cp_nxt; cont_r <= cont_nxt; pend_r <= pend_nxt;
      used_r <= used_nxt; fi_r <= fi_nxt; is_r <= is_nxt; priv_r <= priv_nxt;
      g0_r <= g0_nxt; g1_r <= g1_nxt; so_r <= so_nxt; osc_r <= osc_nxt;
    end
  end

  // Payload registers: current parameter, dispatch context, second result, walk
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_r <= cur_nxt;
      dsp_r <= dsp_nxt;
      sec_r <= res1;
    end
    if (cmd.accept) widx_r <= '0;
    else if (cmd.walk_step) widx_r <= widx_r + 1'b1;
  end

  // Parameter store
  always_ff @(posedge clk) begin
    if (cmd.accept && mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[widx_r[PADDR_W-1:0]];
  end

  // Walk beat: dispatch context with the parameter just read
  always_comb begin
    walk_res    = dsp_r;
    walk_res.pi = widx_r;
    walk_res.pv = rd_data_r[20:0];
    walk_res.po = rd_data_r[21];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (cmd.load != LD_NONE) valid_r <= 1'b1;
    else if (out_tready) valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    case (cmd.load)
      LD_FIRST:  out_r <= res0;
      LD_SECOND: out_r <= sec_r;
      LD_WALK:   out_r <= walk_res;
      default: ;
    endcase
    if (cmd.load != LD_NONE) last_r <= cmd.last;
  end

  assign st.nres      = nres;
  assign st.out_free  = !valid_r || out_tready;
  assign st.walk_done = (widx_r == dsp_r.pt - 1'b1);
  assign out_valid    = valid_r;
  assign out_res      = out_r;
  assign out_last     = last_r;

endmodule
`default_nettype wire
